/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent checks on a clocked interface.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is skipped while reset is high
`define CHK_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that also runs during reset
`define CHK_PROP_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hw/rtl/ntc_pkg.sv */
// ----------------------------------------------------------------------------
// ntc_pkg
// Types and constants shared by the nearest target centering unit.
// ----------------------------------------------------------------------------
package ntc_pkg;

   // Register map
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 5;
   localparam int REG_IDX_BITS  = 3;

   localparam logic [REG_IDX_BITS-1:0] REG_CENTER_X    = 3'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_CENTER_Y    = 3'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_CENTER_EN   = 3'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_JUMP_THRESH = 3'd3;
   localparam logic [REG_IDX_BITS-1:0] REG_LOST_LIMIT  = 3'd4;
   localparam logic [REG_IDX_BITS-1:0] REG_FINE_BAND   = 3'd5;
   localparam logic [REG_IDX_BITS-1:0] REG_COARSE_BAND = 3'd6;

   // Reset values
   localparam int CENTER_X_RST    = 320;
   localparam int CENTER_Y_RST    = 240;
   localparam int JUMP_THRESH_RST = 7;
   localparam int LOST_LIMIT_RST  = 15;
   localparam int FINE_BAND_RST   = 5;
   localparam int COARSE_BAND_RST = 25;

   // Lost frame counter
   localparam int LOST_BITS = 5;
   localparam logic [LOST_BITS-1:0] LOST_MAX = 5'd31;

   // Step commands
   localparam int MOVE_BITS = 3;
   typedef logic signed [MOVE_BITS-1:0] move_type;
   localparam move_type MOVE_NEG2 = -3'sd2;
   localparam move_type MOVE_NEG1 = -3'sd1;
   localparam move_type MOVE_NONE = 3'sd0;
   localparam move_type MOVE_POS1 = 3'sd1;
   localparam move_type MOVE_POS2 = 3'sd2;

   // Frame summary control between selection and tracking
   typedef struct packed {
      logic valid;       // a frame ended, summary registered
      logic has_items;   // frame was not marked empty
      logic bypass_hit;  // selected entry was written in the ending cycle
   } frame_ctl_type;

endpackage

/* hw/rtl/ntc_ram.sv */
// ----------------------------------------------------------------------------
// ntc_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module ntc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]   rd_addr,
   output logic [WIDTH-1:0]                             rd_data_ff
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

/* hw/rtl/ntc_csr.sv */
// ----------------------------------------------------------------------------
// ntc_csr
// Configuration registers behind a simple APB-style port.
// ----------------------------------------------------------------------------
module ntc_csr #(
   parameter int COORD_BITS = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ntc_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [ntc_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [ntc_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready,
   output logic [COORD_BITS-1:0]              ctr_col,
   output logic [COORD_BITS-1:0]              ctr_row,
   output logic                               centering_enable,
   output logic [COORD_BITS:0]                jump_threshold,
   output logic [ntc_pkg::LOST_BITS-1:0]      lost_limit,
   output logic [COORD_BITS-1:0]              fine_band,
   output logic [COORD_BITS-1:0]              coarse_band
);
   localparam int DB = ntc_pkg::CSR_DATA_BITS;

   logic [COORD_BITS-1:0]         ctr_col_ff, ctr_row_ff;
   logic                          enable_ff;
   logic [COORD_BITS:0]           thresh_ff;
   logic [ntc_pkg::LOST_BITS-1:0] limit_ff;
   logic [COORD_BITS-1:0]         fine_ff, coarse_ff;
   logic [ntc_pkg::REG_IDX_BITS-1:0] reg_idx;
   logic                          wr_en;

   assign reg_idx    = csr_paddr[ntc_pkg::CSR_ADDR_BITS-1:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctr_col_ff <= COORD_BITS'(ntc_pkg::CENTER_X_RST);
         ctr_row_ff <= COORD_BITS'(ntc_pkg::CENTER_Y_RST);
         enable_ff  <= 1'b0;
         thresh_ff  <= (COORD_BITS+1)'(ntc_pkg::JUMP_THRESH_RST);
         limit_ff   <= ntc_pkg::LOST_BITS'(ntc_pkg::LOST_LIMIT_RST);
         fine_ff    <= COORD_BITS'(ntc_pkg::FINE_BAND_RST);
         coarse_ff  <= COORD_BITS'(ntc_pkg::COARSE_BAND_RST);
      end else if (wr_en) begin
         unique case (reg_idx)
            ntc_pkg::REG_CENTER_X:    ctr_col_ff <= csr_pwdata[COORD_BITS-1:0];
            ntc_pkg::REG_CENTER_Y:    ctr_row_ff <= csr_pwdata[COORD_BITS-1:0];
            ntc_pkg::REG_CENTER_EN:   enable_ff  <= csr_pwdata[0];
            ntc_pkg::REG_JUMP_THRESH: thresh_ff  <= csr_pwdata[COORD_BITS:0];
            ntc_pkg::REG_LOST_LIMIT:  limit_ff   <= csr_pwdata[ntc_pkg::LOST_BITS-1:0];
            ntc_pkg::REG_FINE_BAND:   fine_ff    <= csr_pwdata[COORD_BITS-1:0];
            ntc_pkg::REG_COARSE_BAND: coarse_ff  <= csr_pwdata[COORD_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         ntc_pkg::REG_CENTER_X:    csr_prdata = DB'(ctr_col_ff);
         ntc_pkg::REG_CENTER_Y:    csr_prdata = DB'(ctr_row_ff);
         ntc_pkg::REG_CENTER_EN:   csr_prdata = DB'(enable_ff);
         ntc_pkg::REG_JUMP_THRESH: csr_prdata = DB'(thresh_ff);
         ntc_pkg::REG_LOST_LIMIT:  csr_prdata = DB'(limit_ff);
         ntc_pkg::REG_FINE_BAND:   csr_prdata = DB'(fine_ff);
         ntc_pkg::REG_COARSE_BAND: csr_prdata = DB'(coarse_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   assign ctr_col          = ctr_col_ff;
   assign ctr_row          = ctr_row_ff;
   assign centering_enable = enable_ff;
   assign jump_threshold   = thresh_ff;
   assign lost_limit       = limit_ff;
   assign fine_band        = fine_ff;
   assign coarse_band      = coarse_ff;

endmodule

/* hw/rtl/ntc_select.sv */
// ----------------------------------------------------------------------------
// ntc_select
// Stores each frame's coordinates and keeps a running minimum of the
// Manhattan distance to the image center; registers a frame summary.
// ----------------------------------------------------------------------------
module ntc_select #(
   parameter int MAX_TARGETS = 16,
   parameter int COORD_BITS  = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  logic [COORD_BITS-1:0]  in_x,
   input  logic [COORD_BITS-1:0]  in_y,
   input  logic                   in_last,
   input  logic                   in_empty,
   input  logic [COORD_BITS-1:0]  ctr_col,
   input  logic [COORD_BITS-1:0]  ctr_row,
   output ntc_pkg::frame_ctl_type frame_ctl,
   output logic [COORD_BITS-1:0]  sel_x,
   output logic [COORD_BITS-1:0]  sel_y
);
   localparam int IW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
   localparam int CW = $clog2(MAX_TARGETS + 1);
   localparam int DW = COORD_BITS + 1;
   localparam int EW = 2 * COORD_BITS;

   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [DW-1:0] best_ff, best_in;

   ntc_pkg::frame_ctl_type ctl_ff, ctl_in;
   logic [COORD_BITS-1:0]  byp_x_ff, byp_y_ff;

   logic                  take, room, better, ends;
   logic [COORD_BITS-1:0] dx, dy;
   logic [DW-1:0]         gap, bound;
   logic                  wr_en;
   logic [IW-1:0]         wr_addr;
   logic [EW-1:0]         wr_data, rd_data;

   assign take = advance & in_valid;
   assign ends = in_empty | in_last;
   assign room = count_ff < CW'(MAX_TARGETS);

   assign dx    = (in_x > ctr_col) ? in_x - ctr_col : ctr_col - in_x;
   assign dy    = (in_y > ctr_row) ? in_y - ctr_row : ctr_row - in_y;
   assign gap   = {1'b0, dx} + {1'b0, dy};
   // first item of a frame restarts the minimum at the center sum
   assign bound = (count_ff == '0) ? {1'b0, ctr_col} + {1'b0, ctr_row} : best_ff;
   assign better = gap < bound;

   always_comb begin
      count_in = count_ff;
      idx_in   = idx_ff;
      best_in  = best_ff;
      wr_en    = 1'b0;
      wr_addr  = count_ff[IW-1:0];
      wr_data  = {in_y, in_x};
      if (in_empty) begin
         // empty frame: drop collected items, entry zero becomes blank
         count_in = '0;
         idx_in   = '0;
         wr_en    = take;
         wr_addr  = '0;
         wr_data  = '0;
      end else begin
         wr_en = take & room;
         if (room) begin
            best_in = better ? gap : bound;
            if (better) begin
               idx_in = count_ff[IW-1:0];
            end
         end
         count_in = in_last ? '0 : count_ff + CW'(room);
      end
   end

   always_comb begin
      ctl_in            = '0;
      ctl_in.valid      = in_valid & ends;
      ctl_in.has_items  = ~in_empty;
      ctl_in.bypass_hit = wr_en & (wr_addr == idx_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
         best_ff  <= '0;
         ctl_ff   <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
         if (in_valid) begin
            count_ff <= count_in;
            idx_ff   <= idx_in;
            best_ff  <= best_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byp_x_ff <= in_empty ? '0 : in_x;
         byp_y_ff <= in_empty ? '0 : in_y;
      end
   end

   ntc_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_TARGETS)
   ) u_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (take & ends),
      .rd_addr    (idx_in),
      .rd_data_ff (rd_data)
   );

   assign frame_ctl = ctl_ff;
   assign sel_x = ctl_ff.bypass_hit ? byp_x_ff : rd_data[COORD_BITS-1:0];
   assign sel_y = ctl_ff.bypass_hit ? byp_y_ff : rd_data[EW-1:COORD_BITS];

endmodule

/* hw/rtl/ntc_track.sv */
// ----------------------------------------------------------------------------
// ntc_track
// Focus point tracking, lost frame count and step quantization; holds the
// result register.
// ----------------------------------------------------------------------------
module ntc_track #(
   parameter int COORD_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  ntc_pkg::frame_ctl_type        frame_ctl,
   input  logic [COORD_BITS-1:0]         sel_x,
   input  logic [COORD_BITS-1:0]         sel_y,
   input  logic [COORD_BITS-1:0]         ctr_col,
   input  logic [COORD_BITS-1:0]         ctr_row,
   input  logic                          centering_enable,
   input  logic [COORD_BITS:0]           jump_threshold,
   input  logic [ntc_pkg::LOST_BITS-1:0] lost_limit,
   input  logic [COORD_BITS-1:0]         fine_band,
   input  logic [COORD_BITS-1:0]         coarse_band,
   output logic                          out_valid,
   output ntc_pkg::move_type             move_x,
   output ntc_pkg::move_type             move_y,
   output logic                          focus_changed,
   output logic [COORD_BITS-1:0]         focus_x,
   output logic [COORD_BITS-1:0]         focus_y
);
   localparam int DW = COORD_BITS + 1;

   logic                          valid_ff;
   logic [COORD_BITS-1:0]         fx_ff, fy_ff, fx_in, fy_in;
   logic [ntc_pkg::LOST_BITS-1:0] lost_ff, lost_in;
   ntc_pkg::move_type             mx_ff, my_ff, mx_in, my_in;
   logic                          changed_ff;

   logic                          lost_over, target_seen, jump, update;
   logic [COORD_BITS-1:0]         fx_base, fy_base, ax, ay;
   logic [ntc_pkg::LOST_BITS-1:0] lost_base;
   logic [DW-1:0]                 jump_gap;
   logic signed [DW-1:0]          off_x, off_y;

   function automatic ntc_pkg::move_type quantize(
      input logic signed [DW-1:0] off,
      input logic [COORD_BITS-1:0] fine,
      input logic [COORD_BITS-1:0] coarse
   );
      logic signed [DW-1:0] f, c;
      ntc_pkg::move_type    m;
      f = $signed({1'b0, fine});
      c = $signed({1'b0, coarse});
      if (off > c) begin
         m = ntc_pkg::MOVE_POS2;
      end else if (off > f) begin
         m = ntc_pkg::MOVE_POS1;
      end else if (off < -c) begin
         m = ntc_pkg::MOVE_NEG2;
      end else if (off < -f) begin
         m = ntc_pkg::MOVE_NEG1;
      end else begin
         m = ntc_pkg::MOVE_NONE;
      end
      return m;
   endfunction

   assign update = advance & frame_ctl.valid;

   // too many frames without a target: focus clears before this frame is judged
   assign lost_over = lost_ff > lost_limit;
   assign lost_base = lost_over ? '0 : lost_ff;
   assign fx_base   = lost_over ? '0 : fx_ff;
   assign fy_base   = lost_over ? '0 : fy_ff;

   assign target_seen = sel_x != '0;
   assign ax       = (fx_base > sel_x) ? fx_base - sel_x : sel_x - fx_base;
   assign ay       = (fy_base > sel_y) ? fy_base - sel_y : sel_y - fy_base;
   assign jump_gap = {1'b0, ax} + {1'b0, ay};
   assign jump     = target_seen & (jump_gap > jump_threshold);

   assign off_x = $signed({1'b0, sel_x}) - $signed({1'b0, ctr_col});
   assign off_y = $signed({1'b0, sel_y}) - $signed({1'b0, ctr_row});

   always_comb begin
      fx_in = jump ? sel_x : fx_base;
      fy_in = jump ? sel_y : fy_base;
      if (target_seen) begin
         lost_in = '0;
      end else if (lost_base == ntc_pkg::LOST_MAX) begin
         lost_in = lost_base;
      end else begin
         lost_in = lost_base + 1'b1;
      end
      if (jump && frame_ctl.has_items) begin
         mx_in = quantize(off_x, fine_band, coarse_band);
         my_in = quantize(off_y, fine_band, coarse_band);
      end else begin
         mx_in = ntc_pkg::MOVE_NONE;
         my_in = ntc_pkg::MOVE_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         fx_ff      <= '0;
         fy_ff      <= '0;
         lost_ff    <= '0;
         mx_ff      <= ntc_pkg::MOVE_NONE;
         my_ff      <= ntc_pkg::MOVE_NONE;
         changed_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= frame_ctl.valid;
         if (update) begin
            changed_ff <= centering_enable & jump;
            if (centering_enable) begin
               fx_ff   <= fx_in;
               fy_ff   <= fy_in;
               lost_ff <= lost_in;
               mx_ff   <= mx_in;
               my_ff   <= my_in;
            end
         end
      end
   end

   assign out_valid     = valid_ff;
   assign move_x        = mx_ff;
   assign move_y        = my_ff;
   assign focus_changed = changed_ff;
   assign focus_x       = fx_ff;
   assign focus_y       = fy_ff;

endmodule

/* hw/rtl/nearest_target_centering_unit.sv */
// The last item of a frame passes the input register, the frame summary and the result register to its result item.
// Throughput: one item per cycle while no result waits on rsp_tready; one result item per frame.
// The pipeline (input register, frame summary with store read, result
// register) moves as one; it holds whenever a result waits on rsp_tready.
// Reset: synchronous; clears control, tracking state and registers to defaults.
// The coordinate store is not cleared and holds no data until written.
// ----------------------------------------------------------------------------
// nearest_target_centering_unit
// Picks the target nearest the image center each frame and tracks a focus.
// ----------------------------------------------------------------------------
module nearest_target_centering_unit #(
   parameter int MAX_TARGETS = 16,
   parameter int COORD_BITS  = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: coord_x, coord_y
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [((2 * COORD_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   input  logic                              req_tlast,
   // req_tuser: frame_empty
   input  logic                              req_tuser,
   // rsp_tdata: move_x, move_y, focus_changed, focus_x, focus_y
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [((2 * ntc_pkg::MOVE_BITS + 1 + 2 * COORD_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ntc_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [ntc_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [ntc_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);
   localparam int IW  = 2 * COORD_BITS;
   localparam int OW  = 2 * ntc_pkg::MOVE_BITS + 1 + 2 * COORD_BITS;
   localparam int OBW = ((OW + 7) / 8) * 8;

   logic                          advance;
   logic                          in_valid_ff;
   logic [COORD_BITS-1:0]         in_x_ff, in_y_ff;
   logic                          in_last_ff, in_empty_ff;

   logic [COORD_BITS-1:0]         ctr_col, ctr_row, fine_band, coarse_band;
   logic                          centering_enable;
   logic [COORD_BITS:0]           jump_threshold;
   logic [ntc_pkg::LOST_BITS-1:0] lost_limit;

   ntc_pkg::frame_ctl_type        frame_ctl;
   logic [COORD_BITS-1:0]         sel_x, sel_y, focus_x, focus_y;
   ntc_pkg::move_type             move_x, move_y;
   logic                          focus_changed;

   assign advance    = ~rsp_tvalid | rsp_tready;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance & req_tvalid) begin
         in_x_ff     <= req_tdata[COORD_BITS-1:0];
         in_y_ff     <= req_tdata[IW-1:COORD_BITS];
         in_last_ff  <= req_tlast;
         in_empty_ff <= req_tuser;
      end
   end

   ntc_csr #(
      .COORD_BITS (COORD_BITS)
   ) u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready),
      .ctr_col          (ctr_col),
      .ctr_row          (ctr_row),
      .centering_enable (centering_enable),
      .jump_threshold   (jump_threshold),
      .lost_limit       (lost_limit),
      .fine_band        (fine_band),
      .coarse_band      (coarse_band)
   );

   ntc_select #(
      .MAX_TARGETS (MAX_TARGETS),
      .COORD_BITS  (COORD_BITS)
   ) u_select (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (in_valid_ff),
      .in_x      (in_x_ff),
      .in_y      (in_y_ff),
      .in_last   (in_last_ff),
      .in_empty  (in_empty_ff),
      .ctr_col   (ctr_col),
      .ctr_row   (ctr_row),
      .frame_ctl (frame_ctl),
      .sel_x     (sel_x),
      .sel_y     (sel_y)
   );

   ntc_track #(
      .COORD_BITS (COORD_BITS)
   ) u_track (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .frame_ctl        (frame_ctl),
      .sel_x            (sel_x),
      .sel_y            (sel_y),
      .ctr_col          (ctr_col),
      .ctr_row          (ctr_row),
      .centering_enable (centering_enable),
      .jump_threshold   (jump_threshold),
      .lost_limit       (lost_limit),
      .fine_band        (fine_band),
      .coarse_band      (coarse_band),
      .out_valid        (rsp_tvalid),
      .move_x           (move_x),
      .move_y           (move_y),
      .focus_changed    (focus_changed),
      .focus_x          (focus_x),
      .focus_y          (focus_y)
   );

   assign rsp_tdata = OBW'({focus_y, focus_x, focus_changed, move_y, move_x});

endmodule

/* hw/rtl/ntc_checker.sv */
// ----------------------------------------------------------------------------
// ntc_checker
// Port level checks for the nearest target centering unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ntc_checker #(
   parameter int COORD_BITS = 12
) (
   input logic                clock,
   input logic                reset,
   input logic                req_tready,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [((2 * ntc_pkg::MOVE_BITS + 1 + 2 * COORD_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   input logic                csr_psel,
   input logic                csr_pready
);
   logic       rsp_stall;
   logic [2:0] rsp_move_x;

   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign rsp_move_x = rsp_tdata[2:0];

   // no result item right after reset
   `CHK_PROP_ALWAYS(a_rsp_idle_after_reset, clock, reset |=> !rsp_tvalid, "result after reset")

   // a waiting result holds its payload
   `CHK_PROP(a_rsp_hold, clock, reset, rsp_stall |=> rsp_tvalid && $stable(rsp_tdata), "result changed")

   // a stalled result stalls the whole pipe, input included
   `CHK_PROP(a_stall_blocks_input, clock, reset, rsp_stall |-> !req_tready, "input taken in stall")

   // horizontal step stays at or above -2
   `CHK_PROP(a_move_x_range, clock, reset, rsp_tvalid |-> $signed(rsp_move_x) >= -3'sd2, "move_x low")

   // register port never waits
   `CHK_PROP(a_csr_no_wait, clock, reset, csr_psel |-> csr_pready, "csr_pready low")

endmodule

bind nearest_target_centering_unit ntc_checker #(.COORD_BITS(COORD_BITS)) u_ntc_checker (.*);
